[rtl/core/sound_container_deframer_defines.svh]
// assertion macros for the container deframer
`ifndef SOUND_CONTAINER_DEFRAMER_DEFINES_SVH
`define SOUND_CONTAINER_DEFRAMER_DEFINES_SVH
`define SCD_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("lbl failed");
`define SCD_ASSERT_NXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("lbl failed");
`endif

[rtl/core/scd_pkg.sv]
`timescale 1ns / 1ps
package scd_pkg;
	localparam logic [31:0] MAGIC_WORD = 32'h6D7A7274;
	localparam logic [15:0] TAG_PCM = 16'h0001;
	localparam logic [15:0] TAG_ADPCM = 16'h0002;
	localparam logic [15:0] TAG_XMA2 = 16'h0166;
	localparam logic [15:0] TAG_EXT = 16'hFFFF;
	localparam logic [15:0] EXTRA_ADPCM = 16'd32;
	localparam logic [15:0] EXTRA_EXT = 16'd22;
	localparam logic [15:0] EXTRA_XMA2 = 16'd34;
	localparam logic [30:0] RST_MAX_AMP = 31'd67108864;
	localparam logic [20:0] RST_MAX_BUF = 21'd1048576;
	localparam logic [30:0] RST_MAX_AUDIO = 31'd1073741824;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [4:0] {
		P_MAGIC, P_STAMP, P_FLAG, P_PSTART, P_PSPAN, P_TAG, P_CHAN, P_RATE, P_AVG,
		P_ALIGN, P_BITS, P_EXSIZE, P_EXDATA, P_AMPSIZE, P_AMPSKIP, P_TOTSIZE,
		P_COUNT, P_NSAMP, P_BSIZE, P_BDATA, P_BOVER, P_DONE
	} phase_t;

	typedef enum logic [3:0] {
		ST_OK, ST_MAGIC, ST_HDR_CUT, ST_FMT_CUT, ST_FMT_BAD, ST_CODEC, ST_AMP_CUT,
		ST_AMP_BAD, ST_TBL_CUT, ST_TBL_BAD, ST_BUF_CUT, ST_BUF_BAD, ST_LIMIT,
		ST_EMPTY, ST_NOPLAY
	} status_t;

	typedef enum logic [1:0] {
		K_AUDIO = 2'd0,
		K_EXTRA = 2'd1,
		K_STATUS = 2'd2
	} kind_t;

	localparam logic [1:0] REG_MAX_AMP = 2'd0;
	localparam logic [1:0] REG_MAX_BUF = 2'd1;
	localparam logic [1:0] REG_MAX_AUDIO = 2'd2;

	// front-to-back request: byte plus last flag
	typedef struct packed {
		logic [7:0] data;
		logic last;
	} req_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [3:0] status;
		logic [15:0] tag;
		logic [15:0] chan;
		logic [31:0] rate;
		logic [15:0] bits;
		logic [20:0] bufs;
		logic [30:0] pay;
		logic [31:0] pstart;
		logic [31:0] pspan;
		logic [63:0] stamp;
	} res_t;

	// truncation status per phase
	function automatic logic [3:0] cut_code(input phase_t p);
		case (p)
			P_MAGIC: cut_code = ST_MAGIC;
			P_STAMP, P_FLAG, P_PSTART, P_PSPAN: cut_code = ST_HDR_CUT;
			P_TAG, P_CHAN, P_RATE, P_AVG, P_ALIGN, P_BITS, P_EXSIZE, P_EXDATA:
				cut_code = ST_FMT_CUT;
			P_AMPSIZE: cut_code = ST_AMP_CUT;
			P_AMPSKIP: cut_code = ST_AMP_BAD;
			P_TOTSIZE, P_COUNT: cut_code = ST_TBL_CUT;
			P_NSAMP, P_BSIZE: cut_code = ST_BUF_CUT;
			P_BDATA, P_BOVER: cut_code = ST_BUF_BAD;
			default: cut_code = ST_OK;
		endcase
	endfunction
endpackage

[rtl/core/scd_queue.sv]
`timescale 1ns / 1ps
module scd_queue #(
	parameter int DEPTH = scd_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input scd_pkg::req_t in_req,
	output logic out_valid,
	input logic out_ready,
	output scd_pkg::req_t out_req
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	scd_pkg::req_t mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != (AW+1)'(DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_req = mem_q[rd_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_req;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

[rtl/core/scd_front.sv]
`timescale 1ns / 1ps
module scd_front (
	input logic clk,
	input logic arst_n,
	input logic s_valid,
	output logic s_ready,
	input logic [7:0] s_byte,
	input logic s_last,
	output logic q_valid,
	input logic q_ready,
	output scd_pkg::req_t q_req
);
	// input register stage
	scd_pkg::req_t req_s1;
	logic valid_s1;

	assign s_ready = !valid_s1 || q_ready;
	assign q_valid = valid_s1;
	assign q_req = req_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (s_ready) valid_s1 <= s_valid;
	end

	always_ff @(posedge clk) begin
		if (s_valid && s_ready) begin
			req_s1.data <= s_byte;
			req_s1.last <= s_last;
		end
	end
endmodule

[rtl/core/scd_back.sv]
`timescale 1ns / 1ps
`include "sound_container_deframer_defines.svh"
module scd_back (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_ready,
	input scd_pkg::req_t q_req,
	input logic [30:0] max_amp,
	input logic [20:0] max_buf,
	input logic [30:0] max_audio,
	output logic m_valid,
	input logic m_ready,
	output scd_pkg::res_t m_res
);
	scd_pkg::phase_t phase_q, phase_d;
	logic [2:0] idx_q, idx_d;
	logic [63:0] shift_q, shift_d;
	logic [63:0] stamp_q, stamp_d;
	logic [31:0] pstart_q, pstart_d, pspan_q, pspan_d, rate_q, rate_d;
	logic [15:0] tag_q, tag_d, chan_q, chan_d, bits_q, bits_d, exsz_q, exsz_d;
	logic [15:0] align_q, align_d;
	logic totneg_q, totneg_d;
	logic [30:0] rem_q, rem_d, pay_q, pay_d;
	logic [20:0] decl_q, decl_d, left_q, left_d;
	logic [3:0] err_q, err_d;

	// two-entry output buffer
	scd_pkg::res_t ob_q [2];
	logic [1:0] ob_cnt_q;
	logic ob_rd_q;

	logic fire, emit_data, emit_stat, pop;
	scd_pkg::res_t data_res, stat_res;
	logic [7:0] b;
	logic done;
	logic [63:0] v;
	logic [3:0] nb;
	logic [31:0] w;
	logic [3:0] code;
	logic [31:0] sum_chk;

	// accept when the buffer is empty or its only result leaves this cycle
	assign q_ready = (ob_cnt_q == 2'd0) || (ob_cnt_q == 2'd1 && m_ready);
	assign fire = q_valid && q_ready;
	assign b = q_req.data;
	assign pop = m_valid && m_ready;
	assign m_valid = (ob_cnt_q != 2'd0);
	assign m_res = ob_q[ob_rd_q];
	assign w = v[31:0];
	assign sum_chk = {1'b0, pay_q} + {1'b0, w[30:0]};

	function automatic logic codec_ok(input logic [15:0] tag, input logic [15:0] sz);
		if (tag == scd_pkg::TAG_ADPCM) codec_ok = (sz == scd_pkg::EXTRA_ADPCM);
		else if (tag == scd_pkg::TAG_EXT) codec_ok = (sz == scd_pkg::EXTRA_EXT);
		else if (tag == scd_pkg::TAG_XMA2) codec_ok = (sz == scd_pkg::EXTRA_XMA2);
		else codec_ok = 1'b0;
	endfunction

	// field width per phase
	always_comb begin
		case (phase_q)
			scd_pkg::P_MAGIC, scd_pkg::P_PSTART, scd_pkg::P_PSPAN, scd_pkg::P_RATE,
			scd_pkg::P_AVG, scd_pkg::P_AMPSIZE, scd_pkg::P_TOTSIZE, scd_pkg::P_COUNT,
			scd_pkg::P_NSAMP, scd_pkg::P_BSIZE: nb = 4'd4;
			scd_pkg::P_STAMP: nb = 4'd8;
			default: nb = 4'd2;
		endcase
	end

	// field collection and parse
	always_comb begin
		logic big;
		logic [63:0] sh;
		logic [2:0] ni;
		big = (phase_q == scd_pkg::P_MAGIC) || (phase_q == scd_pkg::P_STAMP)
			|| (phase_q == scd_pkg::P_PSTART) || (phase_q == scd_pkg::P_PSPAN)
			|| (phase_q >= scd_pkg::P_AMPSIZE);
		sh = big ? {shift_q[55:0], b} : (shift_q | ({56'd0, b} << {idx_q, 3'b000}));
		ni = idx_q + 3'd1;
		done = ({1'b0, ni} >= nb) || (ni == 3'd0);
		v = sh;
		phase_d = phase_q; idx_d = idx_q; shift_d = shift_q;
		stamp_d = stamp_q; pstart_d = pstart_q; pspan_d = pspan_q; rate_d = rate_q;
		tag_d = tag_q; chan_d = chan_q; bits_d = bits_q; exsz_d = exsz_q;
		align_d = align_q; totneg_d = totneg_q; rem_d = rem_q; pay_d = pay_q;
		decl_d = decl_q; left_d = left_q; err_d = err_q;
		emit_data = 1'b0;
		data_res = '0;
		data_res.data = b;
		if (err_q == scd_pkg::ST_OK && phase_q != scd_pkg::P_FLAG
			&& phase_q != scd_pkg::P_EXDATA && phase_q != scd_pkg::P_AMPSKIP
			&& phase_q != scd_pkg::P_BDATA && phase_q != scd_pkg::P_BOVER
			&& phase_q != scd_pkg::P_DONE) begin
			shift_d = done ? 64'd0 : sh;
			idx_d = done ? 3'd0 : ni;
		end
		if (err_q == scd_pkg::ST_OK) begin
			case (phase_q)
				scd_pkg::P_MAGIC: if (done) begin
					if (w != scd_pkg::MAGIC_WORD) err_d = scd_pkg::ST_MAGIC;
					else phase_d = scd_pkg::P_STAMP;
				end
				scd_pkg::P_STAMP: if (done) begin
					stamp_d = v; phase_d = scd_pkg::P_FLAG;
				end
				scd_pkg::P_FLAG: phase_d = scd_pkg::P_PSTART;
				scd_pkg::P_PSTART: if (done) begin
					pstart_d = w; phase_d = scd_pkg::P_PSPAN;
				end
				scd_pkg::P_PSPAN: if (done) begin
					pspan_d = w; phase_d = scd_pkg::P_TAG;
				end
				scd_pkg::P_TAG: if (done) begin
					tag_d = w[15:0]; phase_d = scd_pkg::P_CHAN;
				end
				scd_pkg::P_CHAN: if (done) begin
					chan_d = w[15:0]; phase_d = scd_pkg::P_RATE;
				end
				scd_pkg::P_RATE: if (done) begin
					rate_d = w; phase_d = scd_pkg::P_AVG;
				end
				scd_pkg::P_AVG: if (done) phase_d = scd_pkg::P_ALIGN;
				scd_pkg::P_ALIGN: if (done) begin
					align_d = w[15:0]; phase_d = scd_pkg::P_BITS;
				end
				scd_pkg::P_BITS: if (done) begin
					bits_d = w[15:0];
					if (chan_q == 16'd0 || rate_q == 32'd0 || align_q == 16'd0)
						err_d = scd_pkg::ST_FMT_BAD;
					else if (tag_q == scd_pkg::TAG_PCM) phase_d = scd_pkg::P_AMPSIZE;
					else phase_d = scd_pkg::P_EXSIZE;
				end
				scd_pkg::P_EXSIZE: if (done) begin
					exsz_d = w[15:0];
					if (w[15:0] == 16'd0) begin
						if (codec_ok(tag_q, 16'd0)) phase_d = scd_pkg::P_AMPSIZE;
						else err_d = scd_pkg::ST_CODEC;
					end else begin
						rem_d = {15'd0, w[15:0]}; phase_d = scd_pkg::P_EXDATA;
					end
				end
				scd_pkg::P_EXDATA: begin
					emit_data = 1'b1;
					data_res.kind = scd_pkg::K_EXTRA;
					rem_d = rem_q - 31'd1;
					if (rem_q == 31'd1) begin
						if (codec_ok(tag_q, exsz_q)) phase_d = scd_pkg::P_AMPSIZE;
						else err_d = scd_pkg::ST_CODEC;
					end
				end
				scd_pkg::P_AMPSIZE: if (done) begin
					if (w[31] || w[30:0] > max_amp) err_d = scd_pkg::ST_AMP_BAD;
					else if (w == 32'd0) phase_d = scd_pkg::P_TOTSIZE;
					else begin
						rem_d = w[30:0]; phase_d = scd_pkg::P_AMPSKIP;
					end
				end
				scd_pkg::P_AMPSKIP: begin
					rem_d = rem_q - 31'd1;
					if (rem_q == 31'd1) phase_d = scd_pkg::P_TOTSIZE;
				end
				scd_pkg::P_TOTSIZE: if (done) begin
					totneg_d = w[31]; phase_d = scd_pkg::P_COUNT;
				end
				scd_pkg::P_COUNT: if (done) begin
					if (totneg_q || w[31] || w[30:0] > {10'd0, max_buf})
						err_d = scd_pkg::ST_TBL_BAD;
					else begin
						decl_d = w[20:0]; left_d = w[20:0];
						phase_d = (w[20:0] == 21'd0) ? scd_pkg::P_DONE : scd_pkg::P_NSAMP;
					end
				end
				scd_pkg::P_NSAMP: if (done) phase_d = scd_pkg::P_BSIZE;
				scd_pkg::P_BSIZE: if (done) begin
					if (w[31]) err_d = scd_pkg::ST_BUF_BAD;
					else if (sum_chk > {1'b0, max_audio}) begin
						if (w == 32'd0) err_d = scd_pkg::ST_LIMIT;
						else begin
							rem_d = w[30:0]; phase_d = scd_pkg::P_BOVER;
						end
					end else if (w == 32'd0) begin
						left_d = left_q - 21'd1;
						phase_d = (left_q == 21'd1) ? scd_pkg::P_DONE : scd_pkg::P_NSAMP;
					end else begin
						rem_d = w[30:0]; phase_d = scd_pkg::P_BDATA;
					end
				end
				scd_pkg::P_BDATA: begin
					emit_data = 1'b1;
					data_res.kind = scd_pkg::K_AUDIO;
					pay_d = pay_q + 31'd1;
					rem_d = rem_q - 31'd1;
					if (rem_q == 31'd1) begin
						left_d = left_q - 21'd1;
						phase_d = (left_q == 21'd1) ? scd_pkg::P_DONE : scd_pkg::P_NSAMP;
					end
				end
				scd_pkg::P_BOVER: begin
					rem_d = rem_q - 31'd1;
					if (rem_q == 31'd1) err_d = scd_pkg::ST_LIMIT;
				end
				default: ;
			endcase
		end
		// final status from the updated state
		emit_stat = q_req.last;
		code = err_d;
		if (code == scd_pkg::ST_OK) code = scd_pkg::cut_code(phase_d);
		if (code == scd_pkg::ST_OK) begin
			if (pay_d == 31'd0) code = scd_pkg::ST_EMPTY;
			else if (tag_d == scd_pkg::TAG_XMA2) code = scd_pkg::ST_NOPLAY;
		end
		stat_res = '0;
		stat_res.kind = scd_pkg::K_STATUS;
		stat_res.status = code;
		if (code == scd_pkg::ST_OK || code == scd_pkg::ST_NOPLAY) begin
			stat_res.tag = tag_d; stat_res.chan = chan_d; stat_res.rate = rate_d;
			stat_res.bits = bits_d; stat_res.bufs = decl_d; stat_res.pay = pay_d;
			stat_res.pstart = pstart_d; stat_res.pspan = pspan_d;
			stat_res.stamp = stamp_d;
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= scd_pkg::P_MAGIC; idx_q <= '0; shift_q <= '0; stamp_q <= '0;
			pstart_q <= '0; pspan_q <= '0; rate_q <= '0; tag_q <= '0; chan_q <= '0;
			bits_q <= '0; exsz_q <= '0; align_q <= '0; totneg_q <= 1'b0; rem_q <= '0;
			pay_q <= '0; decl_q <= '0; left_q <= '0; err_q <= '0;
		end else if (fire) begin
			if (q_req.last) begin
				phase_q <= scd_pkg::P_MAGIC; idx_q <= '0; shift_q <= '0; stamp_q <= '0;
				pstart_q <= '0; pspan_q <= '0; rate_q <= '0; tag_q <= '0;
				chan_q <= '0; bits_q <= '0; exsz_q <= '0; align_q <= '0;
				totneg_q <= 1'b0; rem_q <= '0; pay_q <= '0; decl_q <= '0;
				left_q <= '0; err_q <= '0;
			end else begin
				phase_q <= phase_d; idx_q <= idx_d; shift_q <= shift_d;
				stamp_q <= stamp_d; pstart_q <= pstart_d; pspan_q <= pspan_d;
				rate_q <= rate_d; tag_q <= tag_d; chan_q <= chan_d; bits_q <= bits_d;
				exsz_q <= exsz_d; align_q <= align_d; totneg_q <= totneg_d;
				rem_q <= rem_d; pay_q <= pay_d; decl_q <= decl_d; left_q <= left_d;
				err_q <= err_d;
			end
		end
	end

	// output buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_cnt_q <= '0;
			ob_rd_q <= 1'b0;
		end else if (fire) begin
			ob_cnt_q <= 2'(emit_data) + 2'(emit_stat);
			ob_rd_q <= 1'b0;
		end else if (pop) begin
			ob_cnt_q <= ob_cnt_q - 2'd1;
			ob_rd_q <= ~ob_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			ob_q[0] <= emit_data ? data_res : stat_res;
			ob_q[1] <= stat_res;
		end
	end

	`SCD_ASSERT_IMP(a_no_accept_busy, clk, arst_n, fire, ob_cnt_q == 2'd0 || pop)
	`SCD_ASSERT_NXT(a_last_gives_status, clk, arst_n, fire && q_req.last, m_valid)
	`SCD_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, ob_cnt_q != 2'd3)
	`SCD_ASSERT_NXT(a_reset_after_last, clk, arst_n, fire && q_req.last, phase_q == scd_pkg::P_MAGIC)
	`SCD_ASSERT_NXT(a_err_cleared, clk, arst_n, fire && q_req.last, err_q == scd_pkg::ST_OK)
endmodule

[rtl/core/sound_container_deframer.sv]
`timescale 1ns / 1ps
// data path: a byte enters a register stage, a QDEPTH-entry queue (4 by default), then the
// parser, whose results are registered in a two-entry output buffer
// throughput: one byte per cycle while each byte yields at most one result taken at once;
// a byte with two results (data byte plus status) stalls the next until the first has left
// reset: arst_n clears parse state, queue and output buffer; limits return to defaults
module sound_container_deframer #(
	parameter int QDEPTH = scd_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata, // byte_in
	input logic s_tlast, // last_byte
	output logic m_tvalid,
	input logic m_tready,
	// data_byte, status_code, codec tag, channel_count, sample frequency, sample_bits,
	// buffers_total, payload_bytes, play_start, play_span, stamp (low bits up)
	output logic [271:0] m_tdata,
	output logic [1:0] m_tuser, // kind
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	logic [30:0] max_amp_q, max_audio_q;
	logic [20:0] max_buf_q;
	logic fq_valid, fq_ready, bq_valid, bq_ready;
	scd_pkg::req_t fq_req, bq_req;
	scd_pkg::res_t res;
	logic [1:0] reg_idx;

	assign pready = 1'b1;
	assign reg_idx = paddr[3:2];

	// limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_amp_q <= scd_pkg::RST_MAX_AMP;
			max_buf_q <= scd_pkg::RST_MAX_BUF;
			max_audio_q <= scd_pkg::RST_MAX_AUDIO;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				scd_pkg::REG_MAX_AMP: max_amp_q <= pwdata[30:0];
				scd_pkg::REG_MAX_BUF: max_buf_q <= pwdata[20:0];
				scd_pkg::REG_MAX_AUDIO: max_audio_q <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (reg_idx)
			scd_pkg::REG_MAX_AMP: prdata = {1'b0, max_amp_q};
			scd_pkg::REG_MAX_BUF: prdata = {11'd0, max_buf_q};
			scd_pkg::REG_MAX_AUDIO: prdata = {1'b0, max_audio_q};
			default: prdata = 32'd0;
		endcase
	end

	scd_front u_front (
		.clk(clk), .arst_n(arst_n),
		.s_valid(s_tvalid), .s_ready(s_tready), .s_byte(s_tdata), .s_last(s_tlast),
		.q_valid(fq_valid), .q_ready(fq_ready), .q_req(fq_req)
	);

	scd_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(fq_valid), .in_ready(fq_ready), .in_req(fq_req),
		.out_valid(bq_valid), .out_ready(bq_ready), .out_req(bq_req)
	);

	scd_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(bq_valid), .q_ready(bq_ready), .q_req(bq_req),
		.max_amp(max_amp_q), .max_buf(max_buf_q), .max_audio(max_audio_q),
		.m_valid(m_tvalid), .m_ready(m_tready), .m_res(res)
	);

	assign m_tuser = res.kind;
	assign m_tdata = {res.stamp, res.pspan, res.pstart, res.pay, res.bufs,
		res.bits, res.rate, res.chan, res.tag, res.status, res.data};
endmodule
